FILE: src/binary_cross_morphology_filter_core_assert.svh
// assertion helpers for the cross morphology filter
`ifndef BINARY_CROSS_MORPHOLOGY_FILTER_CORE_ASSERT_SVH
`define BINARY_CROSS_MORPHOLOGY_FILTER_CORE_ASSERT_SVH

// clocked check, masked while reset is held
`define BCMF_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition in one cycle implies a result in the next
`define BCMF_ASSERT_NEXT(label, cond, nxt, msg) \
    `BCMF_ASSERT_CLK(label, (cond) |=> (nxt), msg)

`endif

FILE: src/bcmf_pkg.sv
package bcmf_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // configuration port
    localparam int CFG_DW = 11;
    localparam int CFG_IW = 2;

    typedef enum logic [CFG_IW-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_DILATE_MODE  = 2'd2
    } t_reg_index;

    localparam logic [CFG_DW-1:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [CFG_DW-1:0] IMAGE_HEIGHT_RST = 11'd480;
    localparam logic              DILATE_MODE_RST  = 1'b0;

    // per-transaction position info handed from the counters to the kernel
    typedef struct packed {
        logic emit;
        logic last;
        logic up_ok;
        logic left_ok;
        logic right_ok;
        logic down_ok;
    } t_pos_flags;

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic int f_clamp_dim(logic [CFG_DW-1:0] v, int maxv);
        int r;
        r = int'(v);
        if (r < 1) begin
            r = 1;
        end else if (r > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

endpackage

FILE: src/bcmf_line_buf.sv
module bcmf_line_buf #(
    parameter int DEPTH = 2 * bcmf_pkg::MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  logic                         i_en,
    input  logic [$clog2(DEPTH+1)-1:0]   i_len,
    input  logic                         i_bit,
    output logic                         o_bit
);
    import bcmf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH+1);

    logic          r_mem [DEPTH];
    logic          r_rd;
    logic [AW-1:0] r_ptr;
    logic [AW-1:0] n_ptr;

    // ring of i_len entries: the read gives the bit written i_len transactions ago
    always_comb begin
        n_ptr = r_ptr;
        if (i_clear) begin
            n_ptr = '0;
        end else if (i_en) begin
            if (LW'(r_ptr) == i_len - LW'(1)) begin
                n_ptr = '0;
            end else begin
                n_ptr = r_ptr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else begin
            r_ptr <= n_ptr;
        end
    end

    // read-first storage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd         <= r_mem[r_ptr];
            r_mem[r_ptr] <= i_bit;
        end
    end

    assign o_bit = r_rd;

endmodule

FILE: src/bcmf_ctrl.sv
module bcmf_ctrl #(
    parameter int MAX_WIDTH  = bcmf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bcmf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_clear,
    input  logic                            i_step,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]  i_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0] i_h,
    output bcmf_pkg::t_pos_flags            o_pos
);
    import bcmf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH+1);
    localparam int HW = $clog2(MAX_HEIGHT+1);

    logic [CW-1:0] r_in_col,  n_in_col;
    logic [1:0]    r_in_row,  n_in_row;   // saturates at two
    logic [CW-1:0] r_out_col, n_out_col;
    logic [RW-1:0] r_out_row, n_out_row;

    logic [WW-1:0] in_col_p1;
    logic [WW-1:0] out_col_p1;
    logic [HW-1:0] out_row_p1;
    t_pos_flags    pos;

    always_comb begin
        in_col_p1  = WW'(r_in_col) + WW'(1);
        out_col_p1 = WW'(r_out_col) + WW'(1);
        out_row_p1 = HW'(r_out_row) + HW'(1);

        // a result is due once width+1 transactions of the frame are in
        pos.emit     = (r_in_row == 2'd2) || (r_in_row == 2'd1 && r_in_col != '0);
        pos.up_ok    = r_out_row != '0;
        pos.left_ok  = r_out_col != '0;
        pos.right_ok = out_col_p1 < i_w;
        pos.down_ok  = out_row_p1 < i_h;
        pos.last     = (out_col_p1 == i_w) && (out_row_p1 == i_h);
    end

    assign o_pos = pos;

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (i_clear || (i_step && pos.emit && pos.last)) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (i_step) begin
            if (in_col_p1 >= i_w) begin
                n_in_col = '0;
                n_in_row = (r_in_row == 2'd2) ? 2'd2 : r_in_row + 2'd1;
            end else begin
                n_in_col = CW'(in_col_p1);
            end
            if (pos.emit) begin
                if (!pos.right_ok) begin
                    n_out_col = '0;
                    n_out_row = RW'(out_row_p1);
                end else begin
                    n_out_col = CW'(out_col_p1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

endmodule

FILE: src/bcmf_kernel.sv
module bcmf_kernel (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  bcmf_pkg::t_pos_flags i_pos,
    input  logic                 i_dilate,
    input  logic                 i_px,
    input  logic                 i_row1_px,
    input  logic                 i_row2_px,
    output logic                 o_in_ready,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_pixel_out,
    output logic                 o_frame_last
);
    import bcmf_pkg::*;

    // window taps, named for the pixel being filtered
    logic       r_newest;
    logic       r_down;
    logic       r_centre;
    logic       r_left;
    logic       r_up;
    logic       r_s1_valid;
    t_pos_flags r_s1;
    logic       r_out_valid;
    logic       r_out_px;
    logic       r_out_last;

    logic can_take;
    logic s1_has_res;
    logic res;

    assign can_take   = !r_out_valid || i_ready;
    assign s1_has_res = r_s1_valid && r_s1.emit;
    assign o_in_ready = !s1_has_res || can_take;

    always_comb begin
        if (i_dilate) begin
            res = r_centre
                | (r_s1.up_ok    & r_up)
                | (r_s1.left_ok  & r_left)
                | (r_s1.right_ok & i_row1_px)
                | (r_s1.down_ok  & r_down);
        end else begin
            res = r_centre
                & (!r_s1.up_ok    | r_up)
                & (!r_s1.left_ok  | r_left)
                & (!r_s1.right_ok | i_row1_px)
                & (!r_s1.down_ok  | r_down);
        end
    end

    // taps shift once per accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_newest <= i_px;
            r_down   <= r_newest;
            r_centre <= i_row1_px;
            r_left   <= r_centre;
            r_up     <= i_row2_px;
            r_s1     <= i_pos;
        end
        if (s1_has_res && can_take) begin
            r_out_px   <= res;
            r_out_last <= r_s1.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_step) begin
                r_s1_valid <= 1'b1;
            end else if (!s1_has_res || can_take) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_has_res && can_take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pixel_out  = r_out_px;
    assign o_frame_last = r_out_last;

endmodule

FILE: src/binary_cross_morphology_filter_core.sv
// result path: the result for pixel k is formed from the transaction for item
//   k+width+1, which passes through the r_s1 stage and then the output register
// throughput: one transaction per cycle, set by the two line memories (one read and
//   one write each per transaction) and the two-register datapath, when not stalled
// reset: synchronous, active low; clears counters, pointers and valid flags and
//   restores the register defaults; line memories are not cleared and need no pass
module binary_cross_morphology_filter_core #(
    parameter int MAX_WIDTH  = bcmf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bcmf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_pixel_in,
    input  logic                          i_flush,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_pixel_out,
    output logic                          o_frame_last,
    input  logic                          i_cfg_we,
    input  logic [bcmf_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [bcmf_pkg::CFG_DW-1:0]   i_cfg_data
);
    import bcmf_pkg::*;

    localparam int WW  = $clog2(MAX_WIDTH+1);
    localparam int HW  = $clog2(MAX_HEIGHT+1);
    localparam int LWB = $clog2(2*MAX_WIDTH+1);

    logic [WW-1:0] r_w,      n_w;
    logic [HW-1:0] r_h,      n_h;
    logic          r_dilate, n_dilate;

    logic       w_cfg_clear;
    logic       w_in_ready;
    logic       w_in_fire;
    logic       w_px;
    logic       w_row1_px;
    logic       w_row2_px;
    t_pos_flags w_pos;

    // any write to a known register restarts the frame
    always_comb begin
        n_w         = r_w;
        n_h         = r_h;
        n_dilate    = r_dilate;
        w_cfg_clear = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH: begin
                    n_w         = WW'(f_clamp_dim(i_cfg_data, MAX_WIDTH));
                    w_cfg_clear = 1'b1;
                end
                REG_IMAGE_HEIGHT: begin
                    n_h         = HW'(f_clamp_dim(i_cfg_data, MAX_HEIGHT));
                    w_cfg_clear = 1'b1;
                end
                REG_DILATE_MODE: begin
                    n_dilate    = i_cfg_data[0];
                    w_cfg_clear = 1'b1;
                end
                default: begin
                    w_cfg_clear = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w      <= WW'(f_clamp_dim(IMAGE_WIDTH_RST, MAX_WIDTH));
            r_h      <= HW'(f_clamp_dim(IMAGE_HEIGHT_RST, MAX_HEIGHT));
            r_dilate <= DILATE_MODE_RST;
        end else begin
            r_w      <= n_w;
            r_h      <= n_h;
            r_dilate <= n_dilate;
        end
    end

    assign w_in_fire = i_valid && w_in_ready;
    assign o_ready   = w_in_ready;
    // flush transactions enter the rows as white
    assign w_px      = i_pixel_in && !i_flush;

    bcmf_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_cfg_clear),
        .i_step  (w_in_fire),
        .i_w     (r_w),
        .i_h     (r_h),
        .o_pos   (w_pos)
    );

    // one row back
    bcmf_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_row1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_cfg_clear),
        .i_en    (w_in_fire),
        .i_len   (r_w),
        .i_bit   (w_px),
        .o_bit   (w_row1_px)
    );

    // two rows back
    bcmf_line_buf #(
        .DEPTH (2*MAX_WIDTH)
    ) u_row2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_cfg_clear),
        .i_en    (w_in_fire),
        .i_len   (LWB'({r_w, 1'b0})),
        .i_bit   (w_px),
        .o_bit   (w_row2_px)
    );

    bcmf_kernel u_kernel (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_in_fire),
        .i_pos        (w_pos),
        .i_dilate     (r_dilate),
        .i_px         (w_px),
        .i_row1_px    (w_row1_px),
        .i_row2_px    (w_row2_px),
        .o_in_ready   (w_in_ready),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pixel_out  (o_pixel_out),
        .o_frame_last (o_frame_last)
    );

`include "binary_cross_morphology_filter_core_assert.svh"

    `BCMF_ASSERT_CLK(a_stall_only_when_out_full, !w_in_ready |-> (o_valid && !i_ready), "input stalled with free result path")
    `BCMF_ASSERT_NEXT(a_cfg_restarts_frame, w_cfg_clear, !w_pos.emit && !w_pos.up_ok && !w_pos.left_ok, "config write did not restart frame")
    `BCMF_ASSERT_NEXT(a_last_restarts_frame, w_in_fire && w_pos.emit && w_pos.last, !w_pos.emit && !w_pos.up_ok && !w_pos.left_ok, "frame end did not restart counters")
    `BCMF_ASSERT_CLK(a_last_at_corner, w_pos.last |-> (!w_pos.right_ok && !w_pos.down_ok), "frame end away from bottom right corner")

endmodule

FILE: test/tb_binary_cross_morphology_filter_core.sv
`timescale 1ns / 1ps

module tb_binary_cross_morphology_filter_core;
    import bcmf_pkg::*;

    localparam int MAX_W         = MAX_WIDTH_DEF;
    localparam int MAX_H         = MAX_HEIGHT_DEF;
    localparam int RING_LEN      = 2 * MAX_W + 2;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRINT_CAP     = 100;

    // the one index the port can carry that names no register
    localparam logic [CFG_IW-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic pixel;
        logic last;
    } t_filter_result;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic              i_pixel_in  = 1'b0;
    logic              i_flush     = 1'b0;
    logic              i_ready     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [CFG_DW-1:0] i_cfg_data  = '0;
    logic              o_ready;
    logic              o_valid;
    logic              o_pixel_out;
    logic              o_frame_last;

    binary_cross_morphology_filter_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel_in   (i_pixel_in),
        .i_flush      (i_flush),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pixel_out  (o_pixel_out),
        .o_frame_last (o_frame_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predicted filter state
    bit                ring_px [0:RING_LEN-1];
    int unsigned       ring_head;
    int unsigned       in_col, in_row, out_col, out_row;
    logic [CFG_DW-1:0] cfg_width  = IMAGE_WIDTH_RST;
    logic [CFG_DW-1:0] cfg_height = IMAGE_HEIGHT_RST;
    logic              cfg_dilate = DILATE_MODE_RST;

    t_filter_result pending_pixels [$];
    t_filter_result oldest_pixel;

    int          n_errors = 0;
    int unsigned n_sent   = 0;
    int          src_idle_pct  = 0;
    int          sink_idle_pct = 0;

    function automatic int unsigned eff_dim(input logic [CFG_DW-1:0] raw,
                                            input int unsigned maxv);
        if (raw == '0) return 1;
        if (raw > maxv) return maxv;
        return 32'(raw);
    endfunction

    function automatic void frame_restart();
        ring_head = 0;
        in_col    = 0;
        in_row    = 0;
        out_col   = 0;
        out_row   = 0;
    endfunction

    function automatic bit ring_at(input int unsigned back);
        return ring_px[(ring_head + RING_LEN - back) % RING_LEN];
    endfunction

    function automatic void predict_filtered_pixel(input logic pix, input logic flush);
        int unsigned    w, h;
        bit             emit, acc;
        t_filter_result res;
        w = eff_dim(cfg_width, MAX_W);
        h = eff_dim(cfg_height, MAX_H);
        ring_head = (ring_head + 1) % RING_LEN;
        ring_px[ring_head] = flush ? 1'b0 : pix;
        // output due once the input position reaches width+1
        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (emit) begin
            acc = ring_at(w + 1);
            if (cfg_dilate) begin
                if (out_row > 0) acc |= ring_at(2 * w + 1);
                if (out_col > 0) acc |= ring_at(w + 2);
                if (out_col + 1 < w) acc |= ring_at(w);
                if (out_row + 1 < h) acc |= ring_at(1);
            end else begin
                if (out_row > 0) acc &= ring_at(2 * w + 1);
                if (out_col > 0) acc &= ring_at(w + 2);
                if (out_col + 1 < w) acc &= ring_at(w);
                if (out_row + 1 < h) acc &= ring_at(1);
            end
            res.pixel = acc;
            res.last  = (out_row + 1 == h) && (out_col + 1 == w);
            pending_pixels.push_back(res);
            if (res.last) begin
                frame_restart();
            end else begin
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row++;
                end
            end
        end
    endfunction

    function automatic logic [CFG_DW-1:0] mode_word(input logic m);
        logic [CFG_DW-1:0] v;
        v    = CFG_DW'($urandom);
        v[0] = m;
        return v;
    endfunction

    function automatic logic [CFG_DW-1:0] dim_draw(input int unsigned maxd);
        if ($urandom_range(9) == 0) return '0;
        return CFG_DW'($urandom_range(1, maxd));
    endfunction

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= PRINT_CAP) $display("%0t ns: %s", $time, msg);
    endtask

    task automatic send_item(input logic pix, input logic flush);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid    <= 1'b1;
        i_pixel_in <= pix;
        i_flush    <= flush;
        do @(posedge i_clk); while (!o_ready);
        n_sent++;
        predict_filtered_pixel(pix, flush);
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        hold_until_drained();
        // transactions with no result may still be in the pipeline
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH: begin
                cfg_width = data;
                frame_restart();
            end
            REG_IMAGE_HEIGHT: begin
                cfg_height = data;
                frame_restart();
            end
            REG_DILATE_MODE: begin
                cfg_dilate = data[0];
                frame_restart();
            end
            default: ;
        endcase
    endtask

    // bit i of each vector belongs to transaction i
    task automatic send_seq(input logic [15:0] pix, input logic [15:0] flush, input int n);
        for (int i = 0; i < n; i++) send_item(pix[i], flush[i]);
    endtask

    task automatic send_frame(input int dens, input int noise_pct, input int keep_pct);
        int unsigned w, h, n_pix, n_total;
        w       = eff_dim(cfg_width, MAX_W);
        h       = eff_dim(cfg_height, MAX_H);
        n_pix   = w * h;
        n_total = n_pix + w + 1;
        if (keep_pct < 100) n_total = n_total * keep_pct / 100;
        for (int unsigned idx = 0; idx < n_total; idx++) begin
            if ($urandom_range(199) == 0) hold_until_drained();
            if (idx < n_pix) begin
                if ($urandom_range(99) < noise_pct) begin
                    send_item(1'($urandom_range(1)), 1'b1);
                end else begin
                    send_item($urandom_range(99) < dens, 1'b0);
                end
            end else begin
                if ($urandom_range(99) < noise_pct) begin
                    send_item(1'($urandom_range(1)), 1'b0);
                end else begin
                    send_item(1'($urandom_range(1)), 1'b1);
                end
            end
        end
    endtask

    // 640x480 erosion after reset, frame left unfinished
    task automatic test_reset_defaults();
        for (int i = 0; i < 30; i++) send_item($urandom_range(99) < 90, 1'b0);
    endtask

    task automatic test_directed();
        // zero sizes act as one: single pixel frame, dilation
        write_reg(REG_IMAGE_WIDTH, '0);
        write_reg(REG_IMAGE_HEIGHT, '0);
        write_reg(REG_DILATE_MODE, mode_word(1'b1));
        send_seq(16'b111, 16'b110, 3);
        // 2x2 erosion, all black
        write_reg(REG_IMAGE_WIDTH, 11'd2);
        write_reg(REG_IMAGE_HEIGHT, 11'd2);
        write_reg(REG_DILATE_MODE, mode_word(1'b0));
        send_seq(16'b1111111, 16'b1110000, 7);
        // 2x2 dilation, one black corner, pixel transaction inside the flush phase
        write_reg(REG_DILATE_MODE, mode_word(1'b1));
        send_seq(16'b0111000, 16'b1010000, 7);
        // flush arriving before the frame is complete counts as white
        send_seq(16'b0000011, 16'b1110010, 7);
    endtask

    task automatic test_config_restart();
        write_reg(REG_IMAGE_WIDTH, 11'd2);
        write_reg(REG_IMAGE_HEIGHT, 11'd2);
        write_reg(REG_DILATE_MODE, mode_word(1'b0));
        send_seq(16'b111, 16'b000, 3);
        // unknown index leaves the frame running
        write_reg(REG_UNUSED, 11'h7ff);
        send_seq(16'b0001, 16'b1110, 4);
        send_seq(16'b1101, 16'b0000, 4);
        // same value again still abandons the frame
        write_reg(REG_IMAGE_WIDTH, 11'd2);
        send_seq(16'b10111, 16'b10000, 5);
        hold_until_drained();
        send_seq(16'b01, 16'b11, 2);
    endtask

    // the large sizes are cut short and abandoned by the next register write
    task automatic test_extreme_sizes();
        logic m;
        int   keep;
        for (int k = 0; k < 4; k++) begin
            m = 1'($urandom_range(1));
            case (k)
                0: begin
                    write_reg(REG_IMAGE_WIDTH, 11'h7ff);
                    write_reg(REG_IMAGE_HEIGHT, 11'd1);
                    keep = 2;
                end
                1: begin
                    write_reg(REG_IMAGE_WIDTH, 11'd1024);
                    write_reg(REG_IMAGE_HEIGHT, 11'd2);
                    keep = 1;
                end
                2: begin
                    write_reg(REG_IMAGE_WIDTH, 11'd1);
                    write_reg(REG_IMAGE_HEIGHT, 11'h7ff);
                    keep = 3;
                end
                default: begin
                    write_reg(REG_IMAGE_WIDTH, 11'd1);
                    write_reg(REG_IMAGE_HEIGHT, 11'd1);
                    keep = 100;
                end
            endcase
            write_reg(REG_DILATE_MODE, mode_word(m));
            send_frame(m ? 5 : 95, 0, keep);
        end
    endtask

    task automatic test_random_frames(input int unsigned n_items);
        int unsigned first;
        int          kind;
        first = n_sent;
        while (n_sent - first < n_items) begin
            if ($urandom_range(2) == 0) write_reg(REG_IMAGE_WIDTH, dim_draw(8));
            if ($urandom_range(2) == 0) write_reg(REG_IMAGE_HEIGHT, dim_draw(6));
            if ($urandom_range(2) == 0) begin
                write_reg(REG_DILATE_MODE, mode_word(1'($urandom_range(1))));
            end
            kind = $urandom_range(99);
            if (kind < 80) begin
                send_frame($urandom_range(100), 0, 100);
            end else if (kind < 92) begin
                send_frame($urandom_range(100), 10, 100);
            end else begin
                // broken frame, cut short and abandoned by a register write
                send_frame($urandom_range(100), 5, $urandom_range(5, 95));
                write_reg(REG_DILATE_MODE, mode_word(1'($urandom_range(1))));
            end
        end
    endtask

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                oldest_pixel = pending_pixels.pop_front();
                if (o_pixel_out !== oldest_pixel.pixel) begin
                    report_mismatch($sformatf("pixel_out %b, expected %b",
                                              o_pixel_out, oldest_pixel.pixel));
                end
                if (o_frame_last !== oldest_pixel.last) begin
                    report_mismatch($sformatf("frame_last %b, expected %b",
                                              o_frame_last, oldest_pixel.last));
                end
            end
        end
    end

    initial begin
        frame_restart();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct  = 20;
        sink_idle_pct = 74;
        test_reset_defaults();
        test_directed();
        test_config_restart();
        test_random_frames(70);

        src_idle_pct  = 74;
        sink_idle_pct = 20;
        test_random_frames(70);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_extreme_sizes();
        test_random_frames(60);

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("binary_cross_morphology_filter_core: match");
        end else begin
            $display("binary_cross_morphology_filter_core: mismatch");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("binary_cross_morphology_filter_core: mismatch");
        $finish;
    end

endmodule
